// ===== rtl/core/bbpe_pkg.sv =====
package bbpe_pkg;

    // default fixed-point format of coordinates and parameters
    localparam int FRAC_BITS     = 16;
    localparam int COORD_BITS    = 24;

    // 4x4 control lattice, index = row*4 + column
    localparam int LATTICE_DEPTH = 16;
    localparam int INDEX_BITS    = 4;

    // four column cubics then one row cubic
    localparam int CUBIC_BITS    = 3;

    // request kinds carried in tuser
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_EVAL  = 1'b1;

    // where a lerp result is written back
    typedef enum logic [1:0] {
        DEST_W0,
        DEST_W1,
        DEST_W2,
        DEST_FINAL
    } t_dest;

    // tag that travels through the lerp pipeline next to the data
    typedef struct packed {
        logic                  valid;
        t_dest                 dest;
        logic [CUBIC_BITS-1:0] cubic;
    } t_lerp_tag;

endpackage

// ===== rtl/core/bbpe_ram.sv =====
module bbpe_ram #(
    parameter int WIDTH = 3 * bbpe_pkg::COORD_BITS,
    parameter int DEPTH = bbpe_pkg::LATTICE_DEPTH,
    localparam int ADDR_BITS = $clog2(DEPTH)
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [ADDR_BITS-1:0] i_waddr,
    input  logic [WIDTH-1:0]     i_wdata,
    input  logic [ADDR_BITS-1:0] i_raddr,
    output logic [WIDTH-1:0]     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/bbpe_lerp3.sv =====
module bbpe_lerp3 #(
    parameter int FRAC_BITS  = bbpe_pkg::FRAC_BITS,
    parameter int COORD_BITS = bbpe_pkg::COORD_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bbpe_pkg::t_lerp_tag           i_tag,
    input  logic [2:0][COORD_BITS-1:0]    i_a,      // x, y, z from the lowest bits
    input  logic [2:0][COORD_BITS-1:0]    i_b,
    input  logic [FRAC_BITS:0]            i_t,
    output bbpe_pkg::t_lerp_tag           o_tag,
    output logic [2:0][COORD_BITS-1:0]    o_res
);

    localparam int DIFF_BITS = COORD_BITS + 1;
    localparam int PROD_BITS = COORD_BITS + FRAC_BITS + 3;
    localparam logic signed [PROD_BITS-1:0] ROUND_HALF =
        PROD_BITS'(64'sd1 <<< (FRAC_BITS - 1));

    bbpe_pkg::t_lerp_tag                r_tag;
    logic [2:0][COORD_BITS-1:0]         r_a;
    logic [2:0][DIFF_BITS-1:0]          r_d;
    logic [FRAC_BITS:0]                 r_t;

    // stage one: difference b - a per lane
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag <= '0;
        end else begin
            r_tag <= i_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a <= i_a;
        r_t <= i_t;
        for (int k = 0; k < 3; k++) begin
            r_d[k] <= DIFF_BITS'($signed(i_b[k])) - DIFF_BITS'($signed(i_a[k]));
        end
    end

    // stage two: a + round(t * d / 2^FRAC_BITS), ties toward +inf
    for (genvar k = 0; k < 3; k++) begin : g_lane
        logic signed [PROD_BITS-1:0] prod;
        logic signed [PROD_BITS-1:0] base;
        logic signed [PROD_BITS-1:0] full;

        always_comb begin
            prod = $signed(r_d[k]) * $signed({1'b0, r_t});
            base = PROD_BITS'($signed(r_a[k])) <<< FRAC_BITS;
            full = base + prod + ROUND_HALF;
        end

        assign o_res[k] = full[FRAC_BITS +: COORD_BITS];
    end

    assign o_tag = r_tag;

endmodule

// ===== rtl/core/bicubic_bezier_patch_eval_unit.sv =====
// Evaluate: the request is worked through as a sequence of cubics, and the next request
// is taken only once the sequencer is back in idle, so one evaluation at a time.
// Write requests are taken one per cycle while idle and give no result.
// The schedule is set by the shared three-lane lerp pipeline: five cubics (four columns,
// one row); the column cubics read the lattice RAM one point per cycle, the row cubic the column results.
// Reset: synchronous; per-entry valid flags make the lattice read as the flat grid.
module bicubic_bezier_patch_eval_unit #(
    parameter int FRAC_BITS  = bbpe_pkg::FRAC_BITS,
    parameter int COORD_BITS = bbpe_pkg::COORD_BITS,
    localparam int IN_FIELD_BITS  = bbpe_pkg::INDEX_BITS + 3 * COORD_BITS
                                    + 2 * (FRAC_BITS + 1),
    localparam int IN_TDATA_BITS  = ((IN_FIELD_BITS + 7) / 8) * 8,
    localparam int OUT_TDATA_BITS = ((3 * COORD_BITS + 7) / 8) * 8
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    // point_index, coord_x, coord_y, coord_z, param_u, param_v, zero pad
    input  logic [IN_TDATA_BITS-1:0]  i_s_axis_tdata,
    // req_type
    input  logic [0:0]                i_s_axis_tuser,
    output logic                      o_m_axis_tvalid,
    input  logic                      i_m_axis_tready,
    // surf_x, surf_y, surf_z, zero pad
    output logic [OUT_TDATA_BITS-1:0] o_m_axis_tdata
);

    localparam int IDX_BITS   = bbpe_pkg::INDEX_BITS;
    localparam int DEPTH      = bbpe_pkg::LATTICE_DEPTH;
    localparam int CB         = bbpe_pkg::CUBIC_BITS;
    localparam int PARAM_BITS = FRAC_BITS + 1;

    localparam logic [CB-1:0] U_CUBIC  = CB'(4);
    localparam logic [3:0] STEP_LOAD0  = 4'd1;
    localparam logic [3:0] STEP_LOAD1  = 4'd2;
    localparam logic [3:0] STEP_LOAD2  = 4'd3;
    localparam logic [3:0] STEP_LOAD3  = 4'd4;
    localparam logic [3:0] STEP_L1A    = 4'd3;
    localparam logic [3:0] STEP_L1B    = 4'd4;
    localparam logic [3:0] STEP_L1C    = 4'd5;
    localparam logic [3:0] STEP_L2A    = 4'd6;
    localparam logic [3:0] STEP_L2B    = 4'd7;
    localparam logic [3:0] STEP_LAST   = 4'd9;

    localparam logic [PARAM_BITS-1:0] ONE_T = PARAM_BITS'(1) << FRAC_BITS;
    localparam logic [COORD_BITS-1:0] POS_ONE  = COORD_BITS'(64'sd1 <<< FRAC_BITS);
    localparam logic [COORD_BITS-1:0] POS_HALF = COORD_BITS'(64'sd1 <<< (FRAC_BITS - 1));
    localparam logic [COORD_BITS-1:0] NEG_ONE  = COORD_BITS'(-(64'sd1 <<< FRAC_BITS));
    localparam logic [COORD_BITS-1:0] NEG_HALF =
        COORD_BITS'(-(64'sd1 <<< (FRAC_BITS - 1)));

    typedef logic [2:0][COORD_BITS-1:0] t_vec;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    // pair of working registers fed to the lerp unit
    typedef enum logic [1:0] {
        PAIR_01,
        PAIR_12,
        PAIR_23
    } t_pair;

    // ---------------------------------------------------------------
    // input unpack
    logic                    accept;
    logic                    in_eval;
    logic [IDX_BITS-1:0]     in_index;
    t_vec                    in_point;
    logic [PARAM_BITS-1:0]   in_u;
    logic [PARAM_BITS-1:0]   in_v;

    assign in_eval  = (i_s_axis_tuser[0] == bbpe_pkg::REQ_EVAL);
    assign in_index = i_s_axis_tdata[IDX_BITS-1:0];
    assign in_point[0] = i_s_axis_tdata[IDX_BITS +: COORD_BITS];
    assign in_point[1] = i_s_axis_tdata[IDX_BITS + COORD_BITS +: COORD_BITS];
    assign in_point[2] = i_s_axis_tdata[IDX_BITS + 2 * COORD_BITS +: COORD_BITS];
    assign in_u = i_s_axis_tdata[IDX_BITS + 3 * COORD_BITS +: PARAM_BITS];
    assign in_v = i_s_axis_tdata[IDX_BITS + 3 * COORD_BITS + PARAM_BITS +: PARAM_BITS];

    // ---------------------------------------------------------------
    // registers
    t_state                  r_state, n_state;
    logic [CB-1:0]           r_cubic, n_cubic;
    logic [3:0]              r_step, n_step;
    logic [PARAM_BITS-1:0]   r_u, r_v;
    logic                    r_ovalid;
    t_vec                    r_odata;
    logic [DEPTH-1:0]        r_pvalid;
    logic [IDX_BITS-1:0]     r_rd_idx;
    t_vec                    r_cq;
    t_vec                    r_w0, r_w1, r_w2, r_w3;
    t_vec                    r_colres [4];

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    // ---------------------------------------------------------------
    // lattice RAM: written on write transactions, read by the sequencer
    logic [IDX_BITS-1:0]     rd_addr;
    logic [3*COORD_BITS-1:0] mem_q;
    logic                    mem_we;

    assign rd_addr = {r_step[1:0], r_cubic[1:0]};
    assign mem_we  = accept && !in_eval;

    bbpe_ram #(
        .WIDTH (3 * COORD_BITS),
        .DEPTH (DEPTH)
    ) u_lattice (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (in_index),
        .i_wdata (in_point),
        .i_raddr (rd_addr),
        .o_rdata (mem_q)
    );

    // never-written entries read as the flat grid
    logic [COORD_BITS-1:0] flat_x;
    logic [COORD_BITS-1:0] flat_z;
    t_vec                  lat_val;
    t_vec                  load_val;

    always_comb begin
        case (r_rd_idx[1:0])
            2'd0:    flat_x = NEG_ONE;
            2'd1:    flat_x = NEG_HALF;
            2'd2:    flat_x = POS_HALF;
            default: flat_x = POS_ONE;
        endcase
        case (r_rd_idx[3:2])
            2'd0:    flat_z = NEG_ONE;
            2'd1:    flat_z = NEG_HALF;
            2'd2:    flat_z = POS_HALF;
            default: flat_z = POS_ONE;
        endcase
        if (r_pvalid[r_rd_idx]) begin
            lat_val = mem_q;
        end else begin
            lat_val[0] = flat_x;
            lat_val[1] = '0;
            lat_val[2] = flat_z;
        end
        load_val = (r_cubic == U_CUBIC) ? r_cq : lat_val;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pvalid <= '0;
        end else if (mem_we) begin
            r_pvalid[in_index] <= 1'b1;
        end
    end

    // read-side pipeline: RAM address and column result, registered alongside the RAM read
    always_ff @(posedge i_clk) begin
        r_rd_idx <= rd_addr;
        r_cq     <= r_colres[r_step[1:0]];
    end

    // ---------------------------------------------------------------
    // lerp issue schedule within one cubic
    logic                out_free;
    logic                stall;
    logic                issue;
    t_pair               pair;
    bbpe_pkg::t_dest     dest;
    bbpe_pkg::t_lerp_tag iss_tag;
    bbpe_pkg::t_lerp_tag wb_tag;
    t_vec                op_a, op_b, lerp_res;

    assign out_free = !r_ovalid || i_m_axis_tready;
    assign stall    = (r_step == STEP_LAST) && (r_cubic == U_CUBIC) && !out_free;

    always_comb begin
        issue = 1'b0;
        pair  = PAIR_01;
        dest  = bbpe_pkg::DEST_W0;
        case (r_step)
            STEP_L1A: begin
                issue = 1'b1;
                pair  = PAIR_01;
                dest  = bbpe_pkg::DEST_W0;
            end
            STEP_L1B: begin
                issue = 1'b1;
                pair  = PAIR_12;
                dest  = bbpe_pkg::DEST_W1;
            end
            STEP_L1C: begin
                issue = 1'b1;
                pair  = PAIR_23;
                dest  = bbpe_pkg::DEST_W2;
            end
            STEP_L2A: begin
                issue = 1'b1;
                pair  = PAIR_01;
                dest  = bbpe_pkg::DEST_W0;
            end
            STEP_L2B: begin
                issue = 1'b1;
                pair  = PAIR_12;
                dest  = bbpe_pkg::DEST_W1;
            end
            STEP_LAST: begin
                issue = !stall;
                pair  = PAIR_01;
                dest  = bbpe_pkg::DEST_FINAL;
            end
            default: begin
                issue = 1'b0;
            end
        endcase

        case (pair)
            PAIR_01: begin
                op_a = r_w0;
                op_b = r_w1;
            end
            PAIR_12: begin
                op_a = r_w1;
                op_b = r_w2;
            end
            PAIR_23: begin
                op_a = r_w2;
                op_b = r_w3;
            end
            default: begin
                op_a = r_w0;
                op_b = r_w1;
            end
        endcase

        iss_tag.valid = issue && (r_state == ST_RUN);
        iss_tag.dest  = dest;
        iss_tag.cubic = r_cubic;
    end

    bbpe_lerp3 #(
        .FRAC_BITS  (FRAC_BITS),
        .COORD_BITS (COORD_BITS)
    ) u_lerp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (iss_tag),
        .i_a     (op_a),
        .i_b     (op_b),
        .i_t     ((r_cubic == U_CUBIC) ? r_u : r_v),
        .o_tag   (wb_tag),
        .o_res   (lerp_res)
    );

    // ---------------------------------------------------------------
    // working registers: loads from the read side, lerp write-back
    logic wb_final;
    logic wb_out;

    assign wb_final = wb_tag.valid && (wb_tag.dest == bbpe_pkg::DEST_FINAL);
    assign wb_out   = wb_final && (wb_tag.cubic == U_CUBIC);

    always_ff @(posedge i_clk) begin
        if (r_state == ST_RUN) begin
            case (r_step)
                STEP_LOAD0: r_w0 <= load_val;
                STEP_LOAD1: r_w1 <= load_val;
                STEP_LOAD2: r_w2 <= load_val;
                STEP_LOAD3: r_w3 <= load_val;
                default: begin
                end
            endcase
        end
        if (wb_tag.valid) begin
            case (wb_tag.dest)
                bbpe_pkg::DEST_W0: r_w0 <= lerp_res;
                bbpe_pkg::DEST_W1: r_w1 <= lerp_res;
                bbpe_pkg::DEST_W2: r_w2 <= lerp_res;
                default: begin
                end
            endcase
        end
        if (wb_final && !wb_out) begin
            r_colres[wb_tag.cubic[1:0]] <= lerp_res;
        end
    end

    // ---------------------------------------------------------------
    // sequencer next state
    always_comb begin
        n_state = r_state;
        n_cubic = r_cubic;
        n_step  = r_step;
        case (r_state)
            ST_IDLE: begin
                if (accept && in_eval) begin
                    n_state = ST_RUN;
                    n_cubic = '0;
                    n_step  = '0;
                end
            end
            ST_RUN: begin
                if (r_step == STEP_LAST) begin
                    if (!stall) begin
                        n_step = '0;
                        if (r_cubic == U_CUBIC) begin
                            n_state = ST_IDLE;
                        end else begin
                            n_cubic = r_cubic + CB'(1);
                        end
                    end
                end else begin
                    n_step = r_step + 4'd1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state, parameters and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cubic  <= '0;
            r_step   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cubic <= n_cubic;
            r_step  <= n_step;
            if (wb_out) begin
                r_ovalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
        if (accept && in_eval) begin
            r_u <= (in_u > ONE_T) ? ONE_T : in_u;
            r_v <= (in_v > ONE_T) ? ONE_T : in_v;
        end
        if (wb_out) begin
            r_odata <= lerp_res;
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = OUT_TDATA_BITS'(r_odata);

endmodule
